>>> hdl/cor_pkg.sv
package cor_pkg;

  // sequencer states of the octant walker
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_EMIT
  } cor_state_t;

  // index of one of the eight symmetric pixels of a step
  typedef logic [2:0] cor_pix_idx_t;

  localparam cor_pix_idx_t LAST_PIX = 3'd7;

  // command codes
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

endpackage

>>> hdl/cor_sqrt.sv
module cor_sqrt #(
  parameter int RADIUS_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [2*RADIUS_BITS-1:0] n,
  output logic [RADIUS_BITS-1:0]   root_out,
  output logic                     done
);

  localparam int W = 2 * RADIUS_BITS;

  logic [W-1:0] rem;
  logic [W-1:0] root;
  logic [W-1:0] probe;
  logic         fix;
  logic [W:0]   trial;
  logic         fits;

  // one restoring step of the digit-by-digit root
  assign trial    = {1'b0, root} + {1'b0, probe};
  assign fits     = {1'b0, rem} >= trial;
  assign root_out = root[RADIUS_BITS-1:0];

  // probe walks down two bits per cycle; the last cycle rounds half up
  always_ff @(posedge clk) begin
    if (rst) begin
      probe <= '0;
      fix   <= 1'b0;
      done  <= 1'b0;
    end else if (start) begin
      rem   <= n;
      root  <= '0;
      probe <= {2'b01, {(W-2){1'b0}}};
      fix   <= 1'b1;
      done  <= 1'b0;
    end else if (probe != '0) begin
      if (fits) begin
        rem  <= rem - trial[W-1:0];
        root <= (root >> 1) + probe;
      end else begin
        root <= root >> 1;
      end
      probe <= probe >> 2;
    end else if (fix) begin
      // round up when n lies above root*(root+1)
      if (rem > root) begin
        root <= root + 1'b1;
      end
      fix  <= 1'b0;
      done <= 1'b1;
    end
  end

endmodule

>>> hdl/circle_octant_rasterizer_core.sv
// Circle rasterizer with eight-way symmetry. A start word (cmd 0) loads the
// center, radius and color and produces no output. Each advance
// word (cmd 1) on an active circle produces eight pixel words in the order
// (x,y),(y,x),(x,-y),(y,-x),(-x,y),(-y,x),(-x,-y),(-y,-x) around the center;
// the eighth carries last_of_step, and circle_done when the walk has ended.
// An advance on an idle circle is dropped. The next y is the square root of
// r*r - x*x, rounded half up, from an iterative unit that settles two bits of
// the radicand per cycle. The first seven pixels of an advance may leave while
// the root is still being worked out, and the input is stalled until the
// eighth has been sent. A pending output word does not hold off the next input.
module circle_octant_rasterizer_core #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic [RADIUS_BITS-1:0]       radius,
  input  logic [31:0]                  color,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS:0]   pixel_x,
  output logic signed [COORD_BITS:0]   pixel_y,
  output logic [31:0]                  pixel_color,
  output logic                         last_of_step,
  output logic                         circle_done
);

  import cor_pkg::*;

  localparam int MAG_W = RADIUS_BITS + 1;
  localparam int SQ_W  = 2 * RADIUS_BITS + 2;
  localparam int N_W   = 2 * RADIUS_BITS;
  localparam int SUM_W = ((COORD_BITS > MAG_W) ? COORD_BITS : MAG_W) + 2;

  cor_state_t state, state_next;

  logic                   active;
  logic [MAG_W-1:0]       step_x;
  logic [RADIUS_BITS-1:0] step_y;
  logic [COORD_BITS-1:0]  held_center_x;
  logic [COORD_BITS-1:0]  held_center_y;
  logic [31:0]            held_color;
  logic [SQ_W-1:0]        rad_sq;
  logic [SQ_W-1:0]        x_sq;
  logic [MAG_W-1:0]       emit_x;
  logic [RADIUS_BITS-1:0] emit_y;
  logic                   neg_flag;
  cor_pix_idx_t           kidx;

  logic                   accept;
  logic                   sqrt_start;
  logic                   pix_fire;
  logic                   is_last;
  logic                   walk_done;
  logic [SQ_W-1:0]        n_full;
  logic [SQ_W-1:0]        rad_wide;
  logic [RADIUS_BITS-1:0] root;
  logic                   root_done;

  logic [MAG_W-1:0]       mag_px;
  logic [MAG_W-1:0]       mag_py;
  logic [SUM_W-1:0]       cx_ext;
  logic [SUM_W-1:0]       cy_ext;
  logic [SUM_W-1:0]       px_ext;
  logic [SUM_W-1:0]       py_ext;
  logic [SUM_W-1:0]       sum_x;
  logic [SUM_W-1:0]       sum_y;

  assign accept = in_valid && !in_stall;
  assign n_full = rad_sq - x_sq;

  // radius widened so its square keeps every bit
  assign rad_wide = {{(SQ_W-RADIUS_BITS){1'b0}}, radius};

  // single root unit, used for every step
  cor_sqrt #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .n        (n_full[N_W-1:0]),
    .root_out (root),
    .done     (root_done)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_ADVANCE && active) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (pix_fire && is_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall   = 1'b1;
    sqrt_start = 1'b0;
    pix_fire   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_LAUNCH: begin
        sqrt_start = 1'b1;
      end
      ST_EMIT: begin
        pix_fire = (!out_valid || !out_stall) && (!is_last || neg_flag || root_done);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pixel offset select: odd pixels swap x and y, bit 2 negates x, bit 1 negates y
  assign is_last = (kidx == LAST_PIX);
  assign mag_px  = kidx[0] ? {1'b0, emit_y} : emit_x;
  assign mag_py  = kidx[0] ? emit_x : {1'b0, emit_y};
  assign cx_ext  = {{(SUM_W-COORD_BITS){held_center_x[COORD_BITS-1]}}, held_center_x};
  assign cy_ext  = {{(SUM_W-COORD_BITS){held_center_y[COORD_BITS-1]}}, held_center_y};
  assign px_ext  = {{(SUM_W-MAG_W){1'b0}}, mag_px};
  assign py_ext  = {{(SUM_W-MAG_W){1'b0}}, mag_py};
  assign sum_x   = kidx[2] ? (cx_ext - px_ext) : (cx_ext + px_ext);
  assign sum_y   = kidx[1] ? (cy_ext - py_ext) : (cy_ext + py_ext);

  // walk ends when the root falls below x or the radicand went negative
  assign walk_done = neg_flag || ({1'b0, root} < step_x);

  // circle state and step bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      step_x        <= '0;
      step_y        <= '0;
      held_center_x <= '0;
      held_center_y <= '0;
      held_color    <= '0;
      neg_flag      <= 1'b0;
      kidx          <= '0;
    end else begin
      if (accept && cmd == CMD_START) begin
        held_center_x <= center_x;
        held_center_y <= center_y;
        held_color    <= color;
        rad_sq        <= rad_wide * rad_wide;
        x_sq          <= '0;
        step_x        <= '0;
        step_y        <= radius;
        active        <= 1'b1;
      end else if (accept && active) begin
        // keep this step's point, move x on and x*x with it
        emit_x <= step_x;
        emit_y <= step_y;
        step_x <= step_x + 1'b1;
        x_sq   <= x_sq + {{(SQ_W-MAG_W-1){1'b0}}, step_x, 1'b1};
      end
      if (sqrt_start) begin
        neg_flag <= rad_sq < x_sq;
        kidx     <= '0;
      end
      if (pix_fire) begin
        kidx <= kidx + 1'b1;
        if (is_last) begin
          if (!neg_flag) begin
            step_y <= root;
          end
          if (walk_done) begin
            active <= 1'b0;
          end
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pix_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      pixel_x      <= sum_x[COORD_BITS:0];
      pixel_y      <= sum_y[COORD_BITS:0];
      pixel_color  <= held_color;
      last_of_step <= is_last;
      circle_done  <= is_last && walk_done;
    end
  end

endmodule

>>> test/tb.sv
module tb;
  import cor_pkg::*;

  localparam int CB = 12;
  localparam int RB = 10;
  localparam int RAND_WORDS = 450;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PLAN_LEN = 22;

  typedef enum logic [1:0] {
    FROM_WALK,
    NO_PIXELS,
    CENTER_BURST
  } check_kind_t;

  typedef struct packed {
    logic                 cmd;
    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;
    logic [RB-1:0]        r;
    logic [31:0]          color;
    check_kind_t          kind;
  } stim_row_t;

  typedef struct packed {
    logic signed [CB:0] x;
    logic signed [CB:0] y;
    logic [31:0]        color;
    logic               last;
    logic               done;
  } pixel_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic cmd;
  logic signed [CB-1:0] center_x;
  logic signed [CB-1:0] center_y;
  logic [RB-1:0] radius;
  logic [31:0] color;
  logic out_valid;
  logic out_stall;
  logic signed [CB:0] pixel_x;
  logic signed [CB:0] pixel_y;
  logic [31:0] pixel_color;
  logic last_of_step;
  logic circle_done;

  circle_octant_rasterizer_core #(
    .COORD_BITS(CB),
    .RADIUS_BITS(RB)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .center_x(center_x),
    .center_y(center_y),
    .radius(radius),
    .color(color),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .pixel_color(pixel_color),
    .last_of_step(last_of_step),
    .circle_done(circle_done)
  );

  // directed words; advance rows of the center burst carry the expected center and color
  stim_row_t plan [PLAN_LEN] = '{
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, NO_PIXELS},
    '{CMD_START, 12'sh800, 12'sh7FF, 10'd0, 32'hFFFF_FFFF, NO_PIXELS},
    '{CMD_ADVANCE, 12'sh800, 12'sh7FF, 10'd0, 32'hFFFF_FFFF, CENTER_BURST},
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, NO_PIXELS},
    '{CMD_START, 12'sh7FF, 12'sh800, 10'd1023, 32'h0000_0000, NO_PIXELS},
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, FROM_WALK},
    '{CMD_ADVANCE, 12'sh7FF, 12'sh7FF, 10'd1023, 32'hFFFF_FFFF, FROM_WALK},
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, FROM_WALK},
    '{CMD_START, 12'sh000, 12'sh000, 10'd1, 32'hA5A5_5A5A, NO_PIXELS},
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, FROM_WALK},
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, NO_PIXELS},
    '{CMD_START, -12'sd5, 12'sd9, 10'd7, 32'h1234_5678, NO_PIXELS},
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, FROM_WALK},
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, FROM_WALK},
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, FROM_WALK},
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, FROM_WALK},
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, FROM_WALK},
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, FROM_WALK},
    '{CMD_START, 12'sd100, -12'sd100, 10'd3, 32'h0F0F_F0F0, NO_PIXELS},
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, FROM_WALK},
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, FROM_WALK},
    '{CMD_ADVANCE, 12'sh000, 12'sh000, 10'd0, 32'h0000_0000, FROM_WALK}
  };

  // octant walker state mirrored by the testbench
  logic circle_on;
  logic [RB:0] walk_x;
  logic [RB:0] walk_y;
  logic signed [CB-1:0] held_cx;
  logic signed [CB-1:0] held_cy;
  logic [RB-1:0] held_r;
  logic [31:0] held_color;
  pixel_t step_pix [8];

  pixel_t pixels_due [$];
  pixel_t want;
  int bad_count = 0;
  int cycles = 0;
  bit hold_req;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // largest y that is 0 or has y*(y-1) < n
  function automatic logic [RB:0] half_up_root(input longint n);
    logic [RB:0] y;
    longint t;
    y = '0;
    for (int b = RB; b >= 0; b--) begin
      t = longint'(y) | (longint'(1) << b);
      if (t * (t - 1) < n) y = t[RB:0];
    end
    return y;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // apply one word to the mirrored walker, filling step_pix on an advance
  task automatic rasterize(input stim_row_t w, output int cnt);
    int xs, ys, t;
    int dx [8];
    int dy [8];
    longint n;
    logic fin;
    cnt = 0;
    if (w.cmd == CMD_START) begin
      held_cx = w.cx;
      held_cy = w.cy;
      held_r = w.r;
      held_color = w.color;
      walk_x = '0;
      walk_y = {1'b0, w.r};
      circle_on = 1'b1;
    end else if (circle_on) begin
      xs = int'(walk_x);
      ys = int'(walk_y);
      dx = '{xs, ys, xs, ys, -xs, -ys, -xs, -ys};
      dy = '{ys, xs, -ys, -xs, ys, xs, -ys, -xs};
      walk_x = walk_x + 1'b1;
      n = longint'(held_r) * longint'(held_r) - longint'(walk_x) * longint'(walk_x);
      if (n < 0) begin
        fin = 1'b1;
      end else begin
        walk_y = half_up_root(n);
        fin = walk_y < walk_x;
      end
      if (fin) circle_on = 1'b0;
      for (int k = 0; k < 8; k++) begin
        t = int'(held_cx) + dx[k];
        step_pix[k].x = t[CB:0];
        t = int'(held_cy) + dy[k];
        step_pix[k].y = t[CB:0];
        step_pix[k].color = held_color;
        step_pix[k].last = (k == 7);
        step_pix[k].done = (k == 7) && fin;
      end
      cnt = 8;
    end
  endtask

  // offer one word, wait for it to be taken, queue the pixels it yields
  task automatic send_word(input stim_row_t w, output int cnt);
    int g;
    pixel_t p;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= w.cmd;
    center_x <= w.cx;
    center_y <= w.cy;
    radius <= w.r;
    color <= w.color;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rasterize(w, cnt);
    case (w.kind)
      FROM_WALK: begin
        for (int k = 0; k < cnt; k++) pixels_due = {pixels_due, step_pix[k]};
      end
      CENTER_BURST: begin
        for (int k = 0; k < 8; k++) begin
          p.x = {w.cx[CB-1], w.cx};
          p.y = {w.cy[CB-1], w.cy};
          p.color = w.color;
          p.last = (k == 7);
          p.done = (k == 7);
          pixels_due = {pixels_due, p};
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_bad(input string msg);
    bad_count++;
    if (bad_count <= 10) $display("%s", msg);
  endtask

  // output side stall pattern, with one long hold-off on request
  initial begin
    out_stall = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (gap_len() + 1) @(posedge clk);
        out_stall <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  // compare each pixel word taken with the oldest one due
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pixels_due.size() == 0) begin
        report_bad($sformatf("unexpected pixel word x=%0d y=%0d color=%h last=%b done=%b",
                             pixel_x, pixel_y, pixel_color, last_of_step, circle_done));
      end else begin
        want = pixels_due.pop_front();
        if (pixel_x !== want.x || pixel_y !== want.y || pixel_color !== want.color ||
            last_of_step !== want.last || circle_done !== want.done)
          report_bad($sformatf({"pixel mismatch: want x=%0d y=%0d color=%h last=%b done=%b",
                                " got x=%0d y=%0d color=%h last=%b done=%b"},
                               want.x, want.y, want.color, want.last, want.done,
                               pixel_x, pixel_y, pixel_color, last_of_step, circle_done));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // stimulus
  initial begin
    stim_row_t w;
    int cnt;
    int words;
    int sel;
    int steps;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_START;
    center_x = '0;
    center_y = '0;
    radius = '0;
    color = '0;
    hold_req = 1'b0;
    circle_on = 1'b0;
    walk_x = '0;
    walk_y = '0;
    held_cx = '0;
    held_cy = '0;
    held_r = '0;
    held_color = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (int i = 0; i < PLAN_LEN; i++) send_word(plan[i], cnt);

    // random part: circles walked out or cut short, with stray advances
    hold_req = 1'b1;
    words = 0;
    while (words < RAND_WORDS) begin
      sel = $urandom_range(0, 99);
      w.cx = CB'($urandom);
      w.cy = CB'($urandom);
      w.color = $urandom;
      w.r = RB'($urandom);
      w.kind = FROM_WALK;
      if (sel < 6) begin
        w.cmd = CMD_ADVANCE;
        send_word(w, cnt);
        if (cnt > 0) words++;
      end else begin
        w.cmd = CMD_START;
        sel = $urandom_range(0, 99);
        if (sel < 70) w.r = RB'($urandom_range(0, 20));
        else if (sel < 90) w.r = RB'($urandom_range(21, 120));
        send_word(w, cnt);
        words++;
        steps = (w.r <= 20) ? 1000 : $urandom_range(1, 10);
        while (circle_on && steps > 0) begin
          w.cmd = CMD_ADVANCE;
          w.cx = CB'($urandom);
          w.cy = CB'($urandom);
          w.r = RB'($urandom);
          w.color = $urandom;
          send_word(w, cnt);
          words++;
          steps--;
        end
      end
    end
    in_valid <= 1'b0;

    // drain, then watch for stray words
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pixels_due.size() != 0)
      report_bad($sformatf("%0d pixel words never arrived", pixels_due.size()));
    if (bad_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/cor_pkg.sv
hdl/cor_sqrt.sv
hdl/circle_octant_rasterizer_core.sv
test/tb.sv
